// File: rtl/vfi_pkg.sv
// Shared types and constants for the venturi flow volume integrator.
// No dependencies; used by every module under rtl/.
package vfi_pkg;

    localparam int LOG_DEPTH_DEF = 4096;

    localparam int READ_W     = 10;
    localparam int SAMPLE_W   = 11;
    localparam int SQ_W       = READ_W + 16;
    localparam int ROOT_W     = 13;
    localparam int GAIN_W     = 16;
    localparam int START_W    = 8;
    localparam int FLOW_W     = 13;
    localparam int ACC_W      = 32;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]         FLOW_GAIN_RST   = 16'd7429;
    localparam logic [START_W-1:0]        START_COUNT_RST = 8'd50;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX       = 10'sd511;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN       = -10'sd512;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_EXHALE  = 2'd1,
        PH_RESULTS = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOW_GAIN   = 1'b0,
        REG_START_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_ROOT  = 2'd1,
        BK_SCALE = 2'd2,
        BK_DONE  = 2'd3
    } t_bk_state;

    typedef struct packed {
        t_op                op;
        logic [READ_W-1:0]  reading;
        logic [IDX_W-1:0]   log_index;
        logic               read_ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// File: rtl/vfi_front.sv
// Front end: accepts input beats, decodes the op, clamps the sample and
// range-checks the log index, then holds commands in a two-entry queue. Uses vfi_pkg.
module vfi_front #(
    parameter int LOG_DEPTH = vfi_pkg::LOG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic signed [vfi_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [vfi_pkg::IDX_W-1:0]       i_log_index,
    output vfi_pkg::t_q_head                o_head,
    input  logic                            i_pop
);

    vfi_pkg::t_cmd w_cmd;
    vfi_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          w_push;

    always_comb begin
        w_cmd.op        = vfi_pkg::t_op'(i_op);
        w_cmd.reading   = i_sample[vfi_pkg::SAMPLE_W-1] ? '0 : i_sample[vfi_pkg::READ_W-1:0];
        w_cmd.log_index = i_log_index;
        w_cmd.read_ok   = (w_cmd.op == vfi_pkg::OP_READ) && (32'(i_log_index) < LOG_DEPTH);
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

// File: rtl/vfi_isqrt.sv
// Iterative integer square root of reading * 65536, one result bit per cycle.
// Uses vfi_pkg.
module vfi_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vfi_pkg::READ_W-1:0]    i_reading,
    output logic                          o_done,
    output logic [vfi_pkg::ROOT_W-1:0]    o_root
);

    localparam int SQ_W = vfi_pkg::SQ_W;

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_root;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] w_trial;
    logic            w_ge;

    assign w_trial = r_root + r_bit;
    assign w_ge    = (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {i_reading, 16'd0};
            r_root <= '0;
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[vfi_pkg::ROOT_W-1:0];

endmodule

// File: rtl/vfi_back.sv
// Back end: runs one command at a time through root, gain scaling and the
// phase/accumulator update, owns the sample log and the output register.
// Uses vfi_pkg and vfi_isqrt.
module vfi_back #(
    parameter int LOG_DEPTH = vfi_pkg::LOG_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vfi_pkg::t_q_head                  i_head,
    output logic                              o_pop,
    input  logic [vfi_pkg::GAIN_W-1:0]        i_flow_gain,
    input  logic [vfi_pkg::START_W-1:0]       i_start_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_phase,
    output logic [vfi_pkg::READ_W-1:0]        o_reading,
    output logic [vfi_pkg::FLOW_W-1:0]        o_flow_q8,
    output logic [vfi_pkg::ACC_W-1:0]         o_volume_total,
    output logic [vfi_pkg::ACC_W-1:0]         o_elapsed_ticks,
    output logic [vfi_pkg::CNT_W-1:0]         o_log_count,
    output logic [vfi_pkg::READ_W-1:0]        o_log_value
);

    localparam int AW     = $clog2(LOG_DEPTH);
    localparam int LW     = $clog2(LOG_DEPTH + 1);
    localparam int READ_W = vfi_pkg::READ_W;
    localparam int ACC_W  = vfi_pkg::ACC_W;
    localparam int PROD_W = vfi_pkg::ROOT_W + vfi_pkg::GAIN_W;

    vfi_pkg::t_bk_state r_state, n_state;

    vfi_pkg::t_cmd                    r_cmd;
    logic [vfi_pkg::FLOW_W-1:0]       r_flow;
    logic [READ_W-1:0]                r_rd_data;
    logic [READ_W-1:0]                r_log_mem [LOG_DEPTH];

    vfi_pkg::t_phase                  r_phase, n_phase;
    logic signed [vfi_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [ACC_W-1:0]                 r_volume, n_volume;
    logic [ACC_W-1:0]                 r_ticks, n_ticks;
    logic                             r_armed, n_armed;
    logic [LW-1:0]                    r_log_fill, n_log_fill;
    logic [READ_W-1:0]                r_last_reading, n_last_reading;
    logic                             w_log_we;

    logic                             r_out_valid;
    vfi_pkg::t_phase                  r_o_phase;
    logic [READ_W-1:0]                r_o_reading;
    logic [vfi_pkg::FLOW_W-1:0]       r_o_flow;
    logic [ACC_W-1:0]                 r_o_volume;
    logic [ACC_W-1:0]                 r_o_ticks;
    logic [vfi_pkg::CNT_W-1:0]        r_o_count;
    logic [READ_W-1:0]                r_o_log_value;

    logic                             w_sq_start;
    logic                             w_sq_done;
    logic [vfi_pkg::ROOT_W-1:0]       w_root;
    logic [READ_W-1:0]                w_sq_reading;
    logic [PROD_W-1:0]                w_prod;
    logic                             w_scale_en;
    logic                             w_commit;
    logic                             w_slot_free;
    logic [AW+vfi_pkg::IDX_W-1:0]     w_idx_ext;
    logic [LW+vfi_pkg::CNT_W-1:0]     w_fill_ext;

    assign w_slot_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vfi_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    n_state = vfi_pkg::BK_ROOT;
                end
            end
            vfi_pkg::BK_ROOT: begin
                if (w_sq_done) begin
                    n_state = vfi_pkg::BK_SCALE;
                end
            end
            vfi_pkg::BK_SCALE: begin
                n_state = vfi_pkg::BK_DONE;
            end
            vfi_pkg::BK_DONE: begin
                if (w_slot_free) begin
                    n_state = vfi_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = vfi_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = 1'b0;
        w_sq_start = 1'b0;
        w_scale_en = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            vfi_pkg::BK_IDLE: begin
                o_pop      = i_head.valid;
                w_sq_start = i_head.valid;
            end
            vfi_pkg::BK_SCALE: begin
                w_scale_en = 1'b1;
            end
            vfi_pkg::BK_DONE: begin
                w_commit = w_slot_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfi_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // non-tick ops report the flow of the last tick's reading
    assign w_sq_reading = (i_head.cmd.op == vfi_pkg::OP_TICK) ? i_head.cmd.reading
                                                               : r_last_reading;

    vfi_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sq_start),
        .i_reading (w_sq_reading),
        .o_done    (w_sq_done),
        .o_root    (w_root)
    );

    assign w_prod = PROD_W'(w_root) * PROD_W'(i_flow_gain);

    assign w_idx_ext = {{AW{1'b0}}, i_head.cmd.log_index};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= i_head.cmd;
            r_rd_data <= r_log_mem[w_idx_ext[AW-1:0]];
        end
        if (w_scale_en) begin
            r_flow <= w_prod[PROD_W-1:16];
        end
        if (w_log_we) begin
            r_log_mem[r_log_fill[AW-1:0]] <= r_cmd.reading;
        end
    end

    always_comb begin
        logic signed [vfi_pkg::LEVEL_W-1:0] v_lvl;
        logic [ACC_W:0]                     v_sum;
        n_phase        = r_phase;
        n_level        = r_level;
        n_volume       = r_volume;
        n_ticks        = r_ticks;
        n_armed        = r_armed;
        n_log_fill     = r_log_fill;
        n_last_reading = r_last_reading;
        w_log_we       = 1'b0;
        v_lvl          = r_level;
        v_sum          = {1'b0, r_volume} + (ACC_W + 1)'(r_flow);
        if (w_commit) begin
            case (r_cmd.op)
                vfi_pkg::OP_TICK: begin
                    n_last_reading = r_cmd.reading;
                    case (r_phase)
                        vfi_pkg::PH_IDLE: begin
                            if (r_cmd.reading != '0 && r_level != vfi_pkg::LEVEL_MAX) begin
                                v_lvl = r_level + 10'sd1;
                            end
                            n_level = v_lvl;
                            if (v_lvl > $signed({2'b00, i_start_count})) begin
                                n_phase = vfi_pkg::PH_EXHALE;
                            end
                        end
                        vfi_pkg::PH_EXHALE: begin
                            if (r_armed) begin
                                n_volume = v_sum[ACC_W] ? '1 : v_sum[ACC_W-1:0];
                            end
                            n_armed = 1'b1;
                            n_ticks = (&r_ticks) ? r_ticks : r_ticks + 32'd1;
                            if (r_cmd.reading == '0 && r_level != vfi_pkg::LEVEL_MIN) begin
                                v_lvl = r_level - 10'sd1;
                            end
                            n_level = v_lvl;
                            if (v_lvl < 0) begin
                                n_phase = vfi_pkg::PH_RESULTS;
                            end
                            if (r_log_fill < LW'(LOG_DEPTH)) begin
                                w_log_we   = 1'b1;
                                n_log_fill = r_log_fill + LW'(1);
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                vfi_pkg::OP_CLEAR: begin
                    n_phase    = vfi_pkg::PH_IDLE;
                    n_volume   = '0;
                    n_ticks    = '0;
                    n_armed    = 1'b0;
                    n_log_fill = '0;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= vfi_pkg::PH_IDLE;
            r_level        <= '0;
            r_volume       <= '0;
            r_ticks        <= '0;
            r_armed        <= 1'b0;
            r_log_fill     <= '0;
            r_last_reading <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_level        <= n_level;
            r_volume       <= n_volume;
            r_ticks        <= n_ticks;
            r_armed        <= n_armed;
            r_log_fill     <= n_log_fill;
            r_last_reading <= n_last_reading;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_fill_ext = {{vfi_pkg::CNT_W{1'b0}}, n_log_fill};

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_phase     <= n_phase;
            r_o_reading   <= n_last_reading;
            r_o_flow      <= r_flow;
            r_o_volume    <= n_volume;
            r_o_ticks     <= n_ticks;
            r_o_count     <= w_fill_ext[vfi_pkg::CNT_W-1:0];
            r_o_log_value <= r_cmd.read_ok ? r_rd_data : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_phase         = r_o_phase;
    assign o_reading       = r_o_reading;
    assign o_flow_q8       = r_o_flow;
    assign o_volume_total  = r_o_volume;
    assign o_elapsed_ticks = r_o_ticks;
    assign o_log_count     = r_o_count;
    assign o_log_value     = r_o_log_value;

endmodule

// File: rtl/venturi_flow_volume_integrator.sv
// Venturi flow volume integrator: the back end takes each item through a dequeue and
// sample log read, 13 bit-serial square root steps and a registered done flag, a scale
// by flow_gain and a commit, and takes no new item before the last one has committed;
// a commit waits while an earlier result is held at the output. A two-entry command
// queue in front keeps accepting beats while the back end works or a result waits at
// the output. Every op returns exactly one result beat. The sample log holds LOG_DEPTH
// entries and is not cleared at reset; only entries logged since power-up are meaningful.
// Configuration is a write-only port with no wait states; write it only while idle.
module venturi_flow_volume_integrator #(
    parameter int LOG_DEPTH = vfi_pkg::LOG_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_op,
    input  logic signed [vfi_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [vfi_pkg::IDX_W-1:0]             i_log_index,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_phase,
    output logic [vfi_pkg::READ_W-1:0]            o_reading,
    output logic [vfi_pkg::FLOW_W-1:0]            o_flow_q8,
    output logic [vfi_pkg::ACC_W-1:0]             o_volume_total,
    output logic [vfi_pkg::ACC_W-1:0]             o_elapsed_ticks,
    output logic [vfi_pkg::CNT_W-1:0]             o_log_count,
    output logic [vfi_pkg::READ_W-1:0]            o_log_value,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vfi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [vfi_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [vfi_pkg::GAIN_W-1:0]  r_flow_gain;
    logic [vfi_pkg::START_W-1:0] r_start_count;
    vfi_pkg::t_q_head            w_head;
    logic                        w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_gain   <= vfi_pkg::FLOW_GAIN_RST;
            r_start_count <= vfi_pkg::START_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (vfi_pkg::t_cfg_reg'(i_cfg_index))
                vfi_pkg::REG_FLOW_GAIN: begin
                    r_flow_gain <= i_cfg_data;
                end
                vfi_pkg::REG_START_COUNT: begin
                    r_start_count <= i_cfg_data[vfi_pkg::START_W-1:0];
                end
                default: begin
                    r_flow_gain <= r_flow_gain;
                end
            endcase
        end
    end

    vfi_front #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_sample    (i_sample),
        .i_log_index (i_log_index),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    vfi_back #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_flow_gain     (r_flow_gain),
        .i_start_count   (r_start_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_phase         (o_phase),
        .o_reading       (o_reading),
        .o_flow_q8       (o_flow_q8),
        .o_volume_total  (o_volume_total),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_log_count     (o_log_count),
        .o_log_value     (o_log_value)
    );

`ifndef SYNTH
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == 2'(vfi_pkg::PH_IDLE)) |->
            (o_elapsed_ticks == '0) && (o_volume_total == '0) && (o_log_count == '0))
        else $error("idle phase with nonzero measurement state");

    a_first_tick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_volume_total != '0) |-> (o_elapsed_ticks > 32'd1))
        else $error("volume accumulated on first exhale tick");

    a_results_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == 2'(vfi_pkg::PH_RESULTS)) |-> (o_elapsed_ticks != '0))
        else $error("results phase without exhale ticks");
`endif

endmodule
